### rtl/ebrle_pkg.sv
package ebrle_pkg;

  // Parser phases of the front end.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYM,
    PH_COUNT,
    PH_EXT,
    PH_VAL
  } ebrle_phase_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_INPUT_LENGTH    = 1'b0,
    CFG_OUTPUT_CAPACITY = 1'b1
  } ebrle_cfg_idx_t;

  localparam int unsigned CFG_WIDTH    = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam logic [7:0]  EXT_FLAG     = 8'h80;
  localparam logic [7:0]  SHORT_MAX    = 8'd2;

  // One decoded symbol, handed from the parser to the run unit.
  typedef struct packed {
    logic        is_start;  // block start record, carries no run
    logic        in_exh;    // input length reached after this symbol
    logic [7:0]  value;
    logic [15:0] length;    // unclipped run length, 1..32768
  } ebrle_rec_t;

endpackage

### rtl/ebrle_channels.sv
// Compressed byte channel.
interface ebrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink (input valid, input data_byte, input block_start, output ready);
endinterface

// Decoded run channel.
interface ebrle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  run_value;
  logic [15:0] run_length;
  logic        block_done;

  modport source (output valid, output run_value, output run_length, output block_done,
                  input ready);
  modport sink (input valid, input run_value, input run_length, input block_done,
                output ready);
endinterface

### rtl/ebrle_front.sv
module ebrle_front (
  input  logic                   clk,
  input  logic                   rst_n,
  ebrle_in_if.sink               in_item,
  input  logic [15:0]            input_length,
  input  logic                   q_full,
  output logic                   q_push,
  output ebrle_pkg::ebrle_rec_t  q_rec
);

  ebrle_pkg::ebrle_phase_t phase_r, phase_nxt;
  logic [7:0]  esc_r, esc_nxt;
  logic [14:0] pcount_r, pcount_nxt;
  logic [16:0] consumed_r, consumed_nxt;
  logic [16:0] consumed_inc;
  logic        accept;
  logic        exh;
  logic        exh_start;

  assign in_item.ready = !q_full;
  assign accept        = in_item.valid && !q_full;

  // Saturating byte count and the input length check after this byte.
  assign consumed_inc = (consumed_r != '1) ? consumed_r + 17'd1 : consumed_r;
  assign exh          = consumed_inc >= {1'b0, input_length};
  assign exh_start    = input_length <= 16'd1;

  // Next parser state.
  always_comb begin
    phase_nxt    = phase_r;
    esc_nxt      = esc_r;
    pcount_nxt   = pcount_r;
    consumed_nxt = consumed_r;
    if (accept) begin
      if (in_item.block_start) begin
        esc_nxt      = in_item.data_byte;
        pcount_nxt   = '0;
        consumed_nxt = 17'd1;
        phase_nxt    = exh_start ? ebrle_pkg::PH_IDLE : ebrle_pkg::PH_SYM;
      end else begin
        unique case (phase_r)
          ebrle_pkg::PH_IDLE: begin
            phase_nxt = ebrle_pkg::PH_IDLE;
          end
          ebrle_pkg::PH_SYM: begin
            consumed_nxt = consumed_inc;
            if (in_item.data_byte != esc_r) begin
              phase_nxt = exh ? ebrle_pkg::PH_IDLE : ebrle_pkg::PH_SYM;
            end else begin
              phase_nxt = ebrle_pkg::PH_COUNT;
            end
          end
          ebrle_pkg::PH_COUNT: begin
            consumed_nxt = consumed_inc;
            if (in_item.data_byte <= ebrle_pkg::SHORT_MAX) begin
              phase_nxt = exh ? ebrle_pkg::PH_IDLE : ebrle_pkg::PH_SYM;
            end else if ((in_item.data_byte & ebrle_pkg::EXT_FLAG) != 8'd0) begin
              pcount_nxt = {in_item.data_byte[6:0], 8'd0};
              phase_nxt  = ebrle_pkg::PH_EXT;
            end else begin
              pcount_nxt = {7'd0, in_item.data_byte};
              phase_nxt  = ebrle_pkg::PH_VAL;
            end
          end
          ebrle_pkg::PH_EXT: begin
            consumed_nxt = consumed_inc;
            pcount_nxt   = {pcount_r[14:8], in_item.data_byte};
            phase_nxt    = ebrle_pkg::PH_VAL;
          end
          ebrle_pkg::PH_VAL: begin
            consumed_nxt = consumed_inc;
            phase_nxt    = exh ? ebrle_pkg::PH_IDLE : ebrle_pkg::PH_SYM;
          end
          default: begin
            phase_nxt = ebrle_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // Symbol and block start records pushed to the queue.
  always_comb begin
    q_push          = 1'b0;
    q_rec.is_start  = 1'b0;
    q_rec.in_exh    = exh;
    q_rec.value     = in_item.data_byte;
    q_rec.length    = 16'd1;
    if (accept) begin
      if (in_item.block_start) begin
        q_push         = 1'b1;
        q_rec.is_start = 1'b1;
        q_rec.in_exh   = exh_start;
      end else begin
        unique case (phase_r)
          ebrle_pkg::PH_SYM: begin
            q_push = in_item.data_byte != esc_r;
          end
          ebrle_pkg::PH_COUNT: begin
            if (in_item.data_byte <= ebrle_pkg::SHORT_MAX) begin
              q_push       = 1'b1;
              q_rec.value  = esc_r;
              q_rec.length = {8'd0, in_item.data_byte} + 16'd1;
            end
          end
          ebrle_pkg::PH_VAL: begin
            q_push       = 1'b1;
            q_rec.length = {1'b0, pcount_r} + 16'd1;
          end
          default: begin
            q_push = 1'b0;
          end
        endcase
      end
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ebrle_pkg::PH_IDLE;
      esc_r      <= '0;
      pcount_r   <= '0;
      consumed_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      esc_r      <= esc_nxt;
      pcount_r   <= pcount_nxt;
      consumed_r <= consumed_nxt;
    end
  end

endmodule

### rtl/ebrle_queue.sv
module ebrle_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ebrle_pkg::ebrle_rec_t  push_rec,
  output logic                   full,
  input  logic                   pop,
  output logic                   not_empty,
  output ebrle_pkg::ebrle_rec_t  pop_rec
);

  localparam int unsigned DEPTH = ebrle_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  ebrle_pkg::ebrle_rec_t slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = count_r == CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign pop_rec   = slots_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

### rtl/ebrle_back.sv
module ebrle_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [15:0]            output_capacity,
  input  logic                   q_valid,
  input  ebrle_pkg::ebrle_rec_t  q_rec,
  output logic                   q_pop,
  ebrle_out_if.source            out_item
);

  logic        live_r, live_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  value_r;
  logic [15:0] length_r;
  logic        done_r;
  logic        emit;
  logic [7:0]  emit_value;
  logic [15:0] emit_length;
  logic        emit_done;
  logic [15:0] clip;
  logic [15:0] rem_left;

  assign q_pop    = q_valid && (!out_valid_r || out_item.ready);
  assign clip     = (q_rec.length < rem_r) ? q_rec.length : rem_r;
  assign rem_left = rem_r - clip;

  // Run clipping and end of block decision.
  always_comb begin
    emit        = 1'b0;
    emit_value  = '0;
    emit_length = '0;
    emit_done   = 1'b0;
    live_nxt    = live_r;
    rem_nxt     = rem_r;
    if (q_pop) begin
      if (q_rec.is_start) begin
        rem_nxt = output_capacity;
        if (q_rec.in_exh || output_capacity == 16'd0) begin
          emit      = 1'b1;
          emit_done = 1'b1;
          live_nxt  = 1'b0;
        end else begin
          live_nxt = 1'b1;
        end
      end else if (live_r) begin
        emit        = 1'b1;
        emit_value  = q_rec.value;
        emit_length = clip;
        emit_done   = (rem_left == 16'd0) || q_rec.in_exh;
        rem_nxt     = rem_left;
        live_nxt    = !emit_done;
      end
    end
  end

  // Output register handshake.
  always_comb begin
    if (q_pop) begin
      out_valid_nxt = emit;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      live_r      <= live_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      value_r  <= emit_value;
      length_r <= emit_length;
      done_r   <= emit_done;
    end
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.run_value  = value_r;
  assign out_item.run_length = length_r;
  assign out_item.block_done = done_r;

endmodule

### rtl/escape_byte_rle_decoder_unit.sv
// Escape-byte run-length decoder. Takes one compressed byte per cycle
// while the queue has room and returns decoded runs as (run_value,
// run_length) with block_done on the run that ends a block; a run_length
// of 0 is a bare completion notice. A parser accepts and classifies bytes
// and pushes one record per complete symbol into a two-entry queue; a run
// unit clips each run to the output capacity left and holds it in the
// output register. The sustained rate is one item per cycle while the
// output is taken; each record waits in a queue slot first. input_length
// and output_capacity must be written through the cfg port between
// blocks, while no item is in flight; the block does not enforce this.
module escape_byte_rle_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  ebrle_in_if.sink    in_item,
  ebrle_out_if.source out_item,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [ebrle_pkg::CFG_WIDTH-1:0] cfg_wdata
);

  logic [15:0]           input_length_r;
  logic [15:0]           output_capacity_r;
  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  ebrle_pkg::ebrle_rec_t push_rec;
  ebrle_pkg::ebrle_rec_t pop_rec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_length_r    <= '0;
      output_capacity_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ebrle_pkg::CFG_INPUT_LENGTH:    input_length_r    <= cfg_wdata[15:0];
        ebrle_pkg::CFG_OUTPUT_CAPACITY: output_capacity_r <= cfg_wdata[15:0];
        default: begin
          input_length_r <= input_length_r;
        end
      endcase
    end
  end

  ebrle_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_item      (in_item),
    .input_length (input_length_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (push_rec)
  );

  ebrle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_rec   (pop_rec)
  );

  ebrle_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .output_capacity (output_capacity_r),
    .q_valid         (q_valid),
    .q_rec           (pop_rec),
    .q_pop           (q_pop),
    .out_item        (out_item)
  );

`ifndef SYNTHESIS
  // A zero-length result is only ever the notice that ends a block.
  a_notice_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.run_length == 16'd0) |-> out_item.block_done)
    else $error("zero-length result without block_done");

  // Clipped runs never exceed the largest count a sequence can encode.
  a_run_length_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> (out_item.run_length <= 16'd32768))
    else $error("run_length above 32768");

  // A pushed symbol record is never dropped by a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("symbol record pushed into a full queue");
`endif

endmodule
